@@ src/plsc_pkg.sv @@
`timescale 1ns / 1ps

package plsc_pkg;

    // Default sizes of the source and subsystem banks.
    localparam int NUM_SOURCES_DEF    = 4;
    localparam int NUM_SUBSYSTEMS_DEF = 6;

    // Field and register widths.
    localparam int REQ_W      = 3;
    localparam int IDX_W      = 3;
    localparam int LOAD_W     = 13;
    localparam int PWR_W      = 16;
    localparam int GEN_W      = 18;
    localparam int SUM_W      = 15;
    localparam int PRIO_W     = 3;
    localparam int PRIOS_W    = 18;
    localparam int STATUS_W   = 2;
    localparam int SRC_MASK_W = 4;
    localparam int SUB_MASK_W = 6;
    localparam int CNT_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int NUM_SRC_CFG = 4;

    // Limits of the load and the priority walk.
    localparam logic [LOAD_W-1:0] MAX_LOAD     = LOAD_W'(5000);
    localparam logic [PRIO_W-1:0] LOWEST_PRIO  = PRIO_W'(6);
    localparam logic [PRIO_W-1:0] HIGHEST_PRIO = PRIO_W'(1);

    // Reset value of the priority register: codes 1 through 6.
    localparam logic [PRIOS_W-1:0] PRIOS_RESET = PRIOS_W'(219345);

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_TOGGLE  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SETLOAD = 3'd1;
    localparam logic [REQ_W-1:0] REQ_AUTO    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RESTORE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_REPORT  = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_INDEX   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_LOAD    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_UNKNOWN = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_POWER_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_POWER_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_POWER_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_POWER_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIORITIES  = 3'd4;

    // Datapath operation selected by a control word.
    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_ACCEPT    = 4'd1,
        OP_EXEC      = 4'd2,
        OP_CLEAR     = 4'd3,
        OP_SUM       = 4'd4,
        OP_INIT_SHED = 4'd5,
        OP_INIT_REST = 4'd6,
        OP_SHED      = 4'd7,
        OP_RESTORE   = 4'd8,
        OP_OUT       = 4'd9
    } op_t;

    // Jump condition of a control word.
    typedef enum logic [3:0] {
        JC_NEVER     = 4'd0,
        JC_ALWAYS    = 4'd1,
        JC_NO_ACCEPT = 4'd2,
        JC_SUM_MORE  = 4'd3,
        JC_SHED_REQ  = 4'd4,
        JC_NOT_REST  = 4'd5,
        JC_REST_MORE = 4'd6,
        JC_SHED_MORE = 4'd7,
        JC_OUT_BUSY  = 4'd8
    } jc_t;

    typedef logic [3:0] upc_t;

    // Program step addresses.
    localparam upc_t ST_WAIT     = 4'd0;
    localparam upc_t ST_EXEC     = 4'd1;
    localparam upc_t ST_CLEAR    = 4'd2;
    localparam upc_t ST_SUM      = 4'd3;
    localparam upc_t ST_BR_SHED  = 4'd4;
    localparam upc_t ST_BR_REST  = 4'd5;
    localparam upc_t ST_REST     = 4'd6;
    localparam upc_t ST_REST_END = 4'd7;
    localparam upc_t ST_SHED     = 4'd8;
    localparam upc_t ST_OUT      = 4'd9;
    localparam upc_t ST_LOOP     = 4'd10;
    localparam upc_t ST_LAST     = ST_LOOP;

    typedef struct packed {
        op_t  op;
        jc_t  jc;
        upc_t target;
    } ucode_t;

    // Status flags that the datapath hands to the sequencer.
    typedef struct packed {
        logic sum_more;
        logic shed_req;
        logic not_rest;
        logic rest_more;
        logic shed_more;
        logic out_busy;
    } dp_flags_t;

    // The control program. A word jumps to its target when its condition
    // holds and otherwise goes on to the next step.
    function automatic ucode_t ucode_rom(input upc_t pc);
        ucode_t w;
        unique case (pc)
            ST_WAIT:     w = '{op: OP_ACCEPT,    jc: JC_NO_ACCEPT, target: ST_WAIT};
            ST_EXEC:     w = '{op: OP_EXEC,      jc: JC_NEVER,     target: ST_WAIT};
            ST_CLEAR:    w = '{op: OP_CLEAR,     jc: JC_NEVER,     target: ST_WAIT};
            ST_SUM:      w = '{op: OP_SUM,       jc: JC_SUM_MORE,  target: ST_SUM};
            ST_BR_SHED:  w = '{op: OP_INIT_SHED, jc: JC_SHED_REQ,  target: ST_SHED};
            ST_BR_REST:  w = '{op: OP_INIT_REST, jc: JC_NOT_REST,  target: ST_OUT};
            ST_REST:     w = '{op: OP_RESTORE,   jc: JC_REST_MORE, target: ST_REST};
            ST_REST_END: w = '{op: OP_NOP,       jc: JC_ALWAYS,    target: ST_OUT};
            ST_SHED:     w = '{op: OP_SHED,      jc: JC_SHED_MORE, target: ST_SHED};
            ST_OUT:      w = '{op: OP_OUT,       jc: JC_OUT_BUSY,  target: ST_OUT};
            ST_LOOP:     w = '{op: OP_NOP,       jc: JC_ALWAYS,    target: ST_WAIT};
            default:     w = '{op: OP_NOP,       jc: JC_ALWAYS,    target: ST_WAIT};
        endcase
        return w;
    endfunction

    // Reset loads of the subsystems.
    function automatic logic [LOAD_W-1:0] load_reset(input int k);
        logic [LOAD_W-1:0] v;
        unique case (k)
            0:       v = LOAD_W'(1500);
            1:       v = LOAD_W'(1800);
            2:       v = LOAD_W'(600);
            3:       v = LOAD_W'(1000);
            4:       v = LOAD_W'(700);
            default: v = LOAD_W'(900);
        endcase
        return v;
    endfunction

    // Reset ratings of the sources.
    function automatic logic [PWR_W-1:0] power_reset(input int k);
        logic [PWR_W-1:0] v;
        unique case (k)
            0:       v = PWR_W'(1200);
            1:       v = PWR_W'(1200);
            2:       v = PWR_W'(3000);
            default: v = PWR_W'(800);
        endcase
        return v;
    endfunction

endpackage

@@ src/plsc_sequencer.sv @@
`timescale 1ns / 1ps

module plsc_sequencer
    import plsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  dp_flags_t flags,
    output op_t       op,
    output logic      in_ready
);

    upc_t   upc_reg;
    upc_t   upc_next;
    ucode_t uword;
    logic   take_jump;

    // Fetch the control word of the current step.
    assign uword    = ucode_rom(upc_reg);
    assign op       = uword.op;
    assign in_ready = (uword.op == OP_ACCEPT);

    // Evaluate the jump condition.
    always_comb
    begin
        unique case (uword.jc)
            JC_NEVER:     take_jump = 1'b0;
            JC_ALWAYS:    take_jump = 1'b1;
            JC_NO_ACCEPT: take_jump = !in_valid;
            JC_SUM_MORE:  take_jump = flags.sum_more;
            JC_SHED_REQ:  take_jump = flags.shed_req;
            JC_NOT_REST:  take_jump = flags.not_rest;
            JC_REST_MORE: take_jump = flags.rest_more;
            JC_SHED_MORE: take_jump = flags.shed_more;
            JC_OUT_BUSY:  take_jump = flags.out_busy;
            default:      take_jump = 1'b1;
        endcase
        upc_next = take_jump ? uword.target : upc_reg + upc_t'(1);
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= ST_WAIT;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    // The step counter stays inside the program.
    a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
        upc_reg <= ST_LAST)
        else $error("step counter left the program");

    // A transfer on the input is always followed by the execute step.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (upc_reg == ST_EXEC))
        else $error("accepted request not executed");

    // The result step is never left while the output register is occupied.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == ST_OUT && flags.out_busy) |=> (upc_reg == ST_OUT))
        else $error("result step left while output busy");

endmodule

@@ src/plsc_datapath.sv @@
`timescale 1ns / 1ps

module plsc_datapath
    import plsc_pkg::*;
#(
    parameter int NUM_SOURCES    = NUM_SOURCES_DEF,
    parameter int NUM_SUBSYSTEMS = NUM_SUBSYSTEMS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  op_t                   op,
    output dp_flags_t             flags,
    input  logic                  in_valid,
    input  logic [REQ_W-1:0]      req_type,
    input  logic [IDX_W-1:0]      target_index,
    input  logic [LOAD_W-1:0]     new_load,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   status,
    output logic [SRC_MASK_W-1:0] online_mask,
    output logic [SUB_MASK_W-1:0] powered_mask,
    output logic [SUB_MASK_W-1:0] changed_mask,
    output logic [GEN_W-1:0]      total_generation,
    output logic [SUM_W-1:0]      total_load,
    output logic [CNT_W-1:0]      shed_count
);

    localparam int SCAN_N = (NUM_SOURCES > NUM_SUBSYSTEMS) ? NUM_SOURCES : NUM_SUBSYSTEMS;
    localparam logic [IDX_W-1:0] SUM_LAST = IDX_W'(SCAN_N - 1);
    localparam logic [IDX_W-1:0] SUB_LAST = IDX_W'(NUM_SUBSYSTEMS - 1);
    localparam logic [IDX_W:0]   SRC_LIM  = (IDX_W + 1)'(NUM_SOURCES);
    localparam logic [IDX_W:0]   SUB_LIM  = (IDX_W + 1)'(NUM_SUBSYSTEMS);

    // Architectural state.
    logic [NUM_SOURCES-1:0]    online_reg, online_next;
    logic [NUM_SUBSYSTEMS-1:0] powered_reg, powered_next;
    logic [LOAD_W-1:0]         load_reg [NUM_SUBSYSTEMS];
    logic [LOAD_W-1:0]         load_next [NUM_SUBSYSTEMS];
    logic [PWR_W-1:0]          src_pwr_reg [NUM_SRC_CFG];
    logic [PWR_W-1:0]          src_pwr_next [NUM_SRC_CFG];
    logic [PRIOS_W-1:0]        prios_reg, prios_next;

    // Loop counters.
    logic [IDX_W-1:0]  scan_i_reg, scan_i_next;
    logic [PRIO_W-1:0] prio_p_reg, prio_p_next;

    // Working registers of the current request.
    logic [REQ_W-1:0]          req_reg, req_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [LOAD_W-1:0]         val_reg, val_next;
    logic [STATUS_W-1:0]       status_reg, status_next;
    logic [NUM_SUBSYSTEMS-1:0] before_reg, before_next;
    logic [GEN_W-1:0]          gen_reg, gen_next;
    logic [SUM_W-1:0]          ld_reg, ld_next;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   status_out_reg;
    logic [SRC_MASK_W-1:0] online_out_reg;
    logic [SUB_MASK_W-1:0] powered_out_reg;
    logic [SUB_MASK_W-1:0] changed_out_reg;
    logic [GEN_W-1:0]      gen_out_reg;
    logic [SUM_W-1:0]      load_out_reg;
    logic [CNT_W-1:0]      shed_out_reg;

    // Element under the scan pointer.
    logic              cur_src_on;
    logic [PWR_W-1:0]  cur_src_pwr;
    logic              cur_powered;
    logic [LOAD_W-1:0] cur_load;
    logic [PRIO_W-1:0] cur_prio;

    logic              fit;
    logic              scan_last;
    logic [IDX_W-1:0]  scan_adv;
    logic [SUM_W:0]    ld_plus;
    logic              out_busy;
    logic              out_load;
    logic [CNT_W-1:0]  shed_cnt;

    // Select the source and the subsystem at the scan pointer.
    always_comb
    begin
        cur_src_on  = 1'b0;
        cur_src_pwr = '0;
        cur_powered = 1'b0;
        cur_load    = '0;
        cur_prio    = '0;
        for (int k = 0; k < NUM_SOURCES; k++)
        begin
            if (scan_i_reg == IDX_W'(k))
            begin
                cur_src_on  = online_reg[k];
                cur_src_pwr = src_pwr_reg[k];
            end
        end
        for (int k = 0; k < NUM_SUBSYSTEMS; k++)
        begin
            if (scan_i_reg == IDX_W'(k))
            begin
                cur_powered = powered_reg[k];
                cur_load    = load_reg[k];
                cur_prio    = prios_reg[PRIO_W*k +: PRIO_W];
            end
        end
    end

    // Compare, scan advance and restore trial sum.
    assign fit       = ({{(GEN_W - SUM_W){1'b0}}, ld_reg} <= gen_reg);
    assign scan_last = (scan_i_reg == SUB_LAST);
    assign scan_adv  = scan_last ? '0 : scan_i_reg + IDX_W'(1);
    assign ld_plus   = {1'b0, ld_reg} + (SUM_W + 1)'(cur_load);
    assign out_busy  = out_valid_reg && !out_ready;
    assign out_load  = (op == OP_OUT) && !out_busy;

    // Flags for the sequencer.
    assign flags.sum_more  = (scan_i_reg != SUM_LAST);
    assign flags.shed_req  = (status_reg == STAT_OK) &&
                             ((req_reg == REQ_TOGGLE) || (req_reg == REQ_SETLOAD) ||
                              (req_reg == REQ_AUTO));
    assign flags.not_rest  = (req_reg != REQ_RESTORE);
    assign flags.rest_more = !((prio_p_reg == LOWEST_PRIO) && scan_last);
    assign flags.shed_more = !fit && !((prio_p_reg == HIGHEST_PRIO) && scan_last);
    assign flags.out_busy  = out_busy;

    // Count of unpowered subsystems.
    always_comb
    begin
        shed_cnt = '0;
        for (int k = 0; k < NUM_SUBSYSTEMS; k++)
        begin
            if (!powered_reg[k])
            begin
                shed_cnt = shed_cnt + CNT_W'(1);
            end
        end
    end

    // Next state of the datapath for the current operation.
    always_comb
    begin
        online_next  = online_reg;
        powered_next = powered_reg;
        load_next    = load_reg;
        src_pwr_next = src_pwr_reg;
        prios_next   = prios_reg;
        scan_i_next  = scan_i_reg;
        prio_p_next  = prio_p_reg;
        req_next     = req_reg;
        idx_next     = idx_reg;
        val_next     = val_reg;
        status_next  = status_reg;
        before_next  = before_reg;
        gen_next     = gen_reg;
        ld_next      = ld_reg;

        unique case (op)
            OP_ACCEPT:
            begin
                if (in_valid)
                begin
                    req_next = req_type;
                    idx_next = target_index;
                    val_next = new_load;
                end
            end
            OP_EXEC:
            begin
                before_next = powered_reg;
                status_next = STAT_OK;
                if (req_reg == REQ_TOGGLE)
                begin
                    if ({1'b0, idx_reg} >= SRC_LIM)
                    begin
                        status_next = STAT_INDEX;
                    end
                    else
                    begin
                        for (int k = 0; k < NUM_SOURCES; k++)
                        begin
                            if (idx_reg == IDX_W'(k))
                            begin
                                online_next[k] = !online_reg[k];
                            end
                        end
                    end
                end
                else if (req_reg == REQ_SETLOAD)
                begin
                    if ({1'b0, idx_reg} >= SUB_LIM)
                    begin
                        status_next = STAT_INDEX;
                    end
                    else if (val_reg > MAX_LOAD)
                    begin
                        status_next = STAT_LOAD;
                    end
                    else
                    begin
                        for (int k = 0; k < NUM_SUBSYSTEMS; k++)
                        begin
                            if (idx_reg == IDX_W'(k))
                            begin
                                load_next[k] = val_reg;
                            end
                        end
                    end
                end
                else if ((req_reg != REQ_AUTO) && (req_reg != REQ_RESTORE) &&
                         (req_reg != REQ_REPORT))
                begin
                    status_next = STAT_UNKNOWN;
                end
            end
            OP_CLEAR:
            begin
                gen_next    = '0;
                ld_next     = '0;
                scan_i_next = '0;
            end
            OP_SUM:
            begin
                gen_next    = gen_reg + (cur_src_on ? GEN_W'(cur_src_pwr) : GEN_W'(0));
                ld_next     = ld_reg + (cur_powered ? SUM_W'(cur_load) : SUM_W'(0));
                scan_i_next = scan_i_reg + IDX_W'(1);
            end
            OP_INIT_SHED:
            begin
                prio_p_next = LOWEST_PRIO;
                scan_i_next = '0;
            end
            OP_INIT_REST:
            begin
                prio_p_next = HIGHEST_PRIO;
                scan_i_next = '0;
            end
            OP_SHED:
            begin
                // Drop the current subsystem while load still exceeds generation.
                if (!fit && cur_powered && (cur_prio == prio_p_reg))
                begin
                    for (int k = 0; k < NUM_SUBSYSTEMS; k++)
                    begin
                        if (scan_i_reg == IDX_W'(k))
                        begin
                            powered_next[k] = 1'b0;
                        end
                    end
                    ld_next = ld_reg - SUM_W'(cur_load);
                end
                scan_i_next = scan_adv;
                if (scan_last)
                begin
                    prio_p_next = prio_p_reg - PRIO_W'(1);
                end
            end
            OP_RESTORE:
            begin
                // Power the current subsystem back on if it still fits.
                if (!cur_powered && (cur_prio == prio_p_reg) &&
                    ({{(GEN_W - SUM_W - 1){1'b0}}, ld_plus} <= gen_reg))
                begin
                    for (int k = 0; k < NUM_SUBSYSTEMS; k++)
                    begin
                        if (scan_i_reg == IDX_W'(k))
                        begin
                            powered_next[k] = 1'b1;
                        end
                    end
                    ld_next = ld_plus[SUM_W-1:0];
                end
                scan_i_next = scan_adv;
                if (scan_last)
                begin
                    prio_p_next = prio_p_reg + PRIO_W'(1);
                end
            end
            OP_OUT, OP_NOP:
            begin
            end
            default:
            begin
            end
        endcase

        // The user must let configuration writes arrive only while the block is idle; the block does not enforce this.
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SRC_POWER_0: src_pwr_next[0] = cfg_data[PWR_W-1:0];
                CFG_SRC_POWER_1: src_pwr_next[1] = cfg_data[PWR_W-1:0];
                CFG_SRC_POWER_2: src_pwr_next[2] = cfg_data[PWR_W-1:0];
                CFG_SRC_POWER_3: src_pwr_next[3] = cfg_data[PWR_W-1:0];
                CFG_PRIORITIES:  prios_next      = cfg_data[PRIOS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Output register valid: set on a load, cleared by a transfer.
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            online_reg    <= '1;
            powered_reg   <= '1;
            for (int k = 0; k < NUM_SUBSYSTEMS; k++)
            begin
                load_reg[k] <= load_reset(k);
            end
            for (int k = 0; k < NUM_SRC_CFG; k++)
            begin
                src_pwr_reg[k] <= power_reset(k);
            end
            prios_reg     <= PRIOS_RESET;
            scan_i_reg    <= '0;
            prio_p_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            online_reg    <= online_next;
            powered_reg   <= powered_next;
            load_reg      <= load_next;
            src_pwr_reg   <= src_pwr_next;
            prios_reg     <= prios_next;
            scan_i_reg    <= scan_i_next;
            prio_p_reg    <= prio_p_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers of the request.
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        idx_reg    <= idx_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        before_reg <= before_next;
        gen_reg    <= gen_next;
        ld_reg     <= ld_next;
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_out_reg  <= status_reg;
            online_out_reg  <= SRC_MASK_W'(online_reg);
            powered_out_reg <= SUB_MASK_W'(powered_reg);
            changed_out_reg <= SUB_MASK_W'(before_reg ^ powered_reg);
            gen_out_reg     <= gen_reg;
            load_out_reg    <= ld_reg;
            shed_out_reg    <= shed_cnt;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_out_reg;
    assign online_mask      = online_out_reg;
    assign powered_mask     = powered_out_reg;
    assign changed_mask     = changed_out_reg;
    assign total_generation = gen_out_reg;
    assign total_load       = load_out_reg;
    assign shed_count       = shed_out_reg;

    // A rejected request never switches a subsystem.
    a_err_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (status_reg != STAT_OK)) |=> (changed_out_reg == '0))
        else $error("rejected request switched a subsystem");

    // Subsystems come back on only during the restore walk.
    a_rise_in_restore: assert property (@(posedge clk) disable iff (!rst_n)
        (op != OP_RESTORE) |=> ((powered_reg & ~$past(powered_reg)) == '0))
        else $error("subsystem powered outside restore");

    // Subsystems go off only during the shed walk.
    a_fall_in_shed: assert property (@(posedge clk) disable iff (!rst_n)
        (op != OP_SHED) |=> ((~powered_reg & $past(powered_reg)) == '0))
        else $error("subsystem shed outside shed walk");

endmodule

@@ src/priority_load_shed_controller_top.sv @@
`timescale 1ns / 1ps

// Priority load-shed controller. Requests arrive on the in_valid/in_ready
// channel and each one produces exactly one result on out_valid/out_ready.
// A small control program steps a shared datapath: steps to take the
// request, apply it, clear the sums and add up generation and load over all
// sources and subsystems, one branch step for a shed request and two for any
// other, then for a shed or restore request a walk over six priorities of one
// subsystem per cycle (shedding stops as soon as load fits, restore adds one
// closing step), and steps to load the result, held while the output register
// is occupied, and return. The result sits in an output register, so the next
// request is taken while the previous result waits for its transfer.
// Configuration writes take effect on the next clock edge.
module priority_load_shed_controller_top
    import plsc_pkg::*;
#(
    parameter int NUM_SOURCES    = NUM_SOURCES_DEF,
    parameter int NUM_SUBSYSTEMS = NUM_SUBSYSTEMS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [REQ_W-1:0]      req_type,
    input  logic [IDX_W-1:0]      target_index,
    input  logic [LOAD_W-1:0]     new_load,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   status,
    output logic [SRC_MASK_W-1:0] online_mask,
    output logic [SUB_MASK_W-1:0] powered_mask,
    output logic [SUB_MASK_W-1:0] changed_mask,
    output logic [GEN_W-1:0]      total_generation,
    output logic [SUM_W-1:0]      total_load,
    output logic [CNT_W-1:0]      shed_count,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    op_t       op;
    dp_flags_t flags;

    // Program sequencer.
    plsc_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .flags    (flags),
        .op       (op),
        .in_ready (in_ready)
    );

    // State, accumulators and result register.
    plsc_datapath #(
        .NUM_SOURCES    (NUM_SOURCES),
        .NUM_SUBSYSTEMS (NUM_SUBSYSTEMS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .op               (op),
        .flags            (flags),
        .in_valid         (in_valid),
        .req_type         (req_type),
        .target_index     (target_index),
        .new_load         (new_load),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .online_mask      (online_mask),
        .powered_mask     (powered_mask),
        .changed_mask     (changed_mask),
        .total_generation (total_generation),
        .total_load       (total_load),
        .shed_count       (shed_count)
    );

endmodule
